>>> design/utf_pkg.sv
// shared types, constants and decode functions for the utf8 text folder
package utf_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       res_kind;
        logic [7:0]  out_byte;
        logic [15:0] text_len;
        logic        res_last;
    } t_out;

    // one classified input byte: held space, up to four bytes, closing result
    typedef struct packed {
        logic            pre_space;
        logic [2:0]      n_bytes;
        logic [3:0][7:0] bytes;
        logic            has_fin;
        logic            fin_err;
        logic [15:0]     text_len;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    localparam logic [15:0] CAP_RESET = 16'd256;
    localparam logic [7:0]  SPACE     = 8'h20;
    localparam logic [7:0]  LEAD_C3   = 8'hC3;
    localparam logic [7:0]  LEAD2_LO  = 8'hC2;
    localparam logic [7:0]  LEAD2_HI  = 8'hDF;
    localparam logic [7:0]  LEAD3_LO  = 8'hE0;
    localparam logic [7:0]  LEAD3_HI  = 8'hEF;
    localparam logic [7:0]  LEAD4_LO  = 8'hF0;
    localparam logic [7:0]  LEAD4_HI  = 8'hF4;
    localparam logic [7:0]  CONT_LO   = 8'h80;
    localparam logic [7:0]  CONT_HI   = 8'hBF;
    localparam logic [7:0]  ASCII_TOP = 8'h80;
    localparam logic [7:0]  CASE_OFS  = 8'h20;

    // unaccented base letter of a c3 trail byte, zero when there is none
    function automatic logic [7:0] base_letter(input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] r;
        lo = b & 8'hDF;
        r  = 8'h00;
        if (b >= CONT_LO && b <= CONT_HI) begin
            if (lo <= 8'h85)                     r = "a";
            else if (lo == 8'h87)                r = "c";
            else if (lo >= 8'h88 && lo <= 8'h8B) r = "e";
            else if (lo >= 8'h8C && lo <= 8'h8F) r = "i";
            else if (lo == 8'h91)                r = "n";
            else if (lo >= 8'h92 && lo <= 8'h96) r = "o";
            else if (lo >= 8'h99 && lo <= 8'h9C) r = "u";
        end
        return r;
    endfunction

    // cjk and full-width punctuation that folds to a space
    function automatic logic is_wide_mark(input logic [23:0] s);
        logic r;
        case (s)
            24'hE38080, 24'hE38081, 24'hE38082, 24'hE383BB, 24'hEFBC8C,
            24'hEFBC81, 24'hEFBC9F, 24'hEFBC9A, 24'hEFBC9B, 24'hE280A6: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        logic r;
        case (c)
            " ", 8'h09, ",", ".", "!", "?", ";", ":", 8'h0A, 8'h0D, "-", 8'h27: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> design/utf_front.sv
// front end: byte decode, sequence tracking, space trimming, capacity check
module utf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  utf_pkg::t_in   i_data,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_q_full,
    output logic           o_push,
    output utf_pkg::t_job  o_job
);

    logic [23:0] r_seq, n_seq;
    logic [1:0]  r_rem, n_rem;
    logic [2:0]  r_width, n_width;
    logic        r_lws, n_lws;
    logic        r_pend, n_pend;
    logic [15:0] r_count, n_count;
    logic        r_disc, n_disc;
    logic [15:0] r_cap;

    logic            acc;
    logic [7:0]      c;
    logic            last;
    logic            err;
    logic [2:0]      flen;
    logic [3:0][7:0] item;
    logic [7:0]      letter;
    logic            mark;
    logic [17:0]     need;
    logic [17:0]     need_sp;
    logic [17:0]     cap_x;
    utf_pkg::t_job   job;

    assign acc    = i_valid && !i_q_full;
    assign c      = i_data.in_byte;
    assign last   = i_data.in_last;
    assign letter = utf_pkg::base_letter(c);
    assign mark   = utf_pkg::is_wide_mark({r_seq[15:0], c});
    assign need    = {2'b00, r_count} + {15'd0, flen} + 18'd1;
    assign need_sp = {2'b00, r_count} + 18'd2;
    assign cap_x   = {2'b00, r_cap};

    always_comb begin
        n_seq   = r_seq;
        n_rem   = r_rem;
        n_width = r_width;
        n_lws   = r_lws;
        n_pend  = r_pend;
        n_count = r_count;
        n_disc  = r_disc;
        err     = 1'b0;
        flen    = 3'd0;
        item    = '0;
        job     = '0;
        if (r_disc) begin
            if (last) begin
                n_seq   = '0;
                n_rem   = '0;
                n_width = '0;
                n_lws   = 1'b1;
                n_pend  = 1'b0;
                n_count = '0;
                n_disc  = 1'b0;
            end
        end else begin
            err = (r_cap == 16'd0);
            if (!err && r_rem != 2'd0) begin
                if (r_width == 3'd2 && r_seq[7:0] == utf_pkg::LEAD_C3) begin
                    if (letter == 8'h00) begin
                        err = 1'b1;
                    end else begin
                        item[0] = letter;
                        flen    = 3'd1;
                    end
                    n_rem = 2'd0;
                end else if (c < utf_pkg::CONT_LO || c > utf_pkg::CONT_HI) begin
                    err = 1'b1;
                end else if (r_rem > 2'd1) begin
                    n_seq = {r_seq[15:0], c};
                    n_rem = r_rem - 2'd1;
                end else begin
                    n_rem = 2'd0;
                    unique case (r_width)
                        3'd3: begin
                            if (mark) begin
                                item[0] = utf_pkg::SPACE;
                                flen    = 3'd1;
                            end else begin
                                item[0] = r_seq[15:8];
                                item[1] = r_seq[7:0];
                                item[2] = c;
                                flen    = 3'd3;
                            end
                        end
                        3'd4: begin
                            item[0] = r_seq[23:16];
                            item[1] = r_seq[15:8];
                            item[2] = r_seq[7:0];
                            item[3] = c;
                            flen    = 3'd4;
                        end
                        default: begin
                            item[0] = r_seq[7:0];
                            item[1] = c;
                            flen    = 3'd2;
                        end
                    endcase
                end
            end else if (!err) begin
                if (c == 8'h00) begin
                    err = 1'b1;
                end else if (c < utf_pkg::ASCII_TOP) begin
                    flen = 3'd1;
                    if (c >= "A" && c <= "Z") begin
                        item[0] = c + utf_pkg::CASE_OFS;
                    end else if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
                        item[0] = c;
                    end else if (utf_pkg::is_sep(c)) begin
                        item[0] = utf_pkg::SPACE;
                    end else begin
                        err = 1'b1;
                    end
                end else if (c >= utf_pkg::LEAD2_LO && c <= utf_pkg::LEAD2_HI) begin
                    n_seq   = {16'd0, c};
                    n_width = 3'd2;
                    n_rem   = 2'd1;
                end else if (c >= utf_pkg::LEAD3_LO && c <= utf_pkg::LEAD3_HI) begin
                    n_seq   = {16'd0, c};
                    n_width = 3'd3;
                    n_rem   = 2'd2;
                end else if (c >= utf_pkg::LEAD4_LO && c <= utf_pkg::LEAD4_HI) begin
                    n_seq   = {16'd0, c};
                    n_width = 3'd4;
                    n_rem   = 2'd3;
                end else begin
                    err = 1'b1;
                end
            end

            if (!err && flen != 3'd0) begin
                if (flen == 3'd1 && item[0] == utf_pkg::SPACE) begin
                    // a space is only held; it goes out ahead of the next non-space
                    if (!r_lws) begin
                        if (need_sp > cap_x) begin
                            err = 1'b1;
                        end else begin
                            n_lws   = 1'b1;
                            n_pend  = 1'b1;
                            n_count = r_count + 16'd1;
                        end
                    end
                end else if (need > cap_x) begin
                    err = 1'b1;
                end else begin
                    job.pre_space = r_pend;
                    job.n_bytes   = flen;
                    job.bytes     = item;
                    n_pend        = 1'b0;
                    n_lws         = 1'b0;
                    n_count       = r_count + {13'd0, flen};
                end
            end

            // message ends inside a multi-byte sequence
            if (!err && last && n_rem != 2'd0) begin
                err = 1'b1;
            end

            if (err || last) begin
                if (err) begin
                    job         = '0;
                    job.fin_err = 1'b1;
                end else begin
                    job.text_len = n_count - {15'd0, n_pend};
                end
                job.has_fin = 1'b1;
                n_seq   = '0;
                n_rem   = '0;
                n_width = '0;
                n_lws   = 1'b1;
                n_pend  = 1'b0;
                n_count = '0;
                n_disc  = err && !last;
            end
        end
    end

    assign o_job  = job;
    assign o_push = acc && (job.pre_space || job.n_bytes != 3'd0 || job.has_fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= '0;
            r_rem   <= '0;
            r_width <= '0;
            r_lws   <= 1'b1;
            r_pend  <= 1'b0;
            r_count <= '0;
            r_disc  <= 1'b0;
            r_cap   <= utf_pkg::CAP_RESET;
        end else begin
            if (acc) begin
                r_seq   <= n_seq;
                r_rem   <= n_rem;
                r_width <= n_width;
                r_lws   <= n_lws;
                r_pend  <= n_pend;
                r_count <= n_count;
                r_disc  <= n_disc;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

endmodule

>>> design/utf_queue.sv
// short job queue between front end and result expander
module utf_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  utf_pkg::t_job   i_job,
    input  logic            i_pop,
    output utf_pkg::t_job   o_head,
    output utf_pkg::t_qstat o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    utf_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt;

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> design/utf_back.sv
// back end: expands each job into results, one transfer per cycle while a job waits and i_stall is low
module utf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  utf_pkg::t_job   i_head,
    input  utf_pkg::t_qstat i_qstat,
    input  logic            i_stall,
    output logic            o_pop,
    output logic            o_valid,
    output utf_pkg::t_out   o_data
);

    logic [2:0]    r_k;
    logic [2:0]    total;
    logic [2:0]    j;
    logic          load;
    logic          at_end;
    logic          r_valid;
    utf_pkg::t_out r_data;
    utf_pkg::t_out res;

    assign total  = {2'b00, i_head.pre_space} + i_head.n_bytes + {2'b00, i_head.has_fin};
    assign j      = r_k - {2'b00, i_head.pre_space};
    assign load   = !i_qstat.empty && (!r_valid || !i_stall);
    assign at_end = (r_k == total - 3'd1);
    assign o_pop  = load && at_end;

    always_comb begin
        res          = '0;
        res.res_kind = utf_pkg::KIND_DATA;
        if (i_head.pre_space && r_k == 3'd0) begin
            res.out_byte = utf_pkg::SPACE;
        end else if (j < i_head.n_bytes) begin
            res.out_byte = i_head.bytes[j[1:0]];
        end else begin
            res.res_last = 1'b1;
            if (i_head.fin_err) begin
                res.res_kind = utf_pkg::KIND_ERROR;
            end else begin
                res.res_kind = utf_pkg::KIND_DONE;
                res.text_len = i_head.text_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_k     <= at_end ? 3'd0 : r_k + 3'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/utf8_text_folder.sv
// with an empty queue, a byte goes into the job queue, then its first result is registered
// throughput: one byte per cycle while the job queue has room; the result expander
// sends one result per cycle while i_stall is low, staying on a job until all its results go
// up to QUEUE_DEPTH classified bytes wait between decode and expander
// reset (synchronous, active low) clears message state and queue, capacity returns to 256
module utf8_text_folder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  utf_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output utf_pkg::t_out o_data,
    input  logic          i_stall,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data
);

    logic            push;
    logic            pop;
    utf_pkg::t_job   job;
    utf_pkg::t_job   head;
    utf_pkg::t_qstat q_stat;

    assign o_stall = q_stat.full;

    utf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_stat.full),
        .o_push     (push),
        .o_job      (job)
    );

    utf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    utf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (q_stat),
        .i_stall (i_stall),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !push)
        else $error("job pushed into a full queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.res_last == (o_data.res_kind != utf_pkg::KIND_DATA)))
        else $error("last flag does not match result kind");

endmodule
